// ----- rtl/core/bpc_pkg.sv -----
// package: types and constants for the button press classifier
package bpc_pkg;

   localparam int unsigned CFG_WIDTH   = 16;
   localparam int unsigned CSR_IDX_W   = 2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd150;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd500;
   localparam logic [CFG_WIDTH-1:0] REPEAT_RESET   = 16'd800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_LONG     = 2'd1,
      CSR_REPEAT   = 2'd2,
      CSR_SUPPRESS = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      PRESS_NONE   = 2'd0,
      PRESS_SHORT  = 2'd1,
      PRESS_LONG   = 2'd2,
      PRESS_REPEAT = 2'd3
   } press_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] repeat_ticks;
      logic                 suppress_view;
   } cfg_type;

   typedef struct packed {
      logic [1:0] press_state;
      logic       view_advance;
   } result_type;

endpackage

// ----- rtl/core/bpc_req_if.sv -----
// interface: input item channel carrying one sampled pin level
interface bpc_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

// ----- rtl/core/bpc_rsp_if.sv -----
// interface: result item channel carrying press state and view advance
interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_state;
   logic       view_advance;

   modport source (output valid, output press_state, output view_advance, input ready);
   modport sink (input valid, input press_state, input view_advance, output ready);
endinterface

// ----- rtl/core/bpc_csr_if.sv -----
// interface: configuration write channel
interface bpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bpc_csr.sv -----
// configuration registers of the button press classifier
module bpc_csr
   import bpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  csr_idx_type          wr_index,
   input  logic [CFG_WIDTH-1:0] wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks   = wr_data;
            CSR_LONG:     cfg_in.long_press_ticks = wr_data;
            CSR_REPEAT:   cfg_in.repeat_ticks     = wr_data;
            CSR_SUPPRESS: cfg_in.suppress_view    = wr_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_RESET;
         cfg_ff.repeat_ticks     <= REPEAT_RESET;
         cfg_ff.suppress_view    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/bpc_core.sv -----
// press state registers and the per-item countdown and classification logic
module bpc_core
   import bpc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       pin,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int unsigned WIDE = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
      logic [WIDE-1:0] w;
      w = (v == '0) ? WIDE'(1) : WIDE'(v);
      if (w > WIDE'(CNT_MAX)) begin
         w = WIDE'(CNT_MAX);
      end
      return w[COUNT_WIDTH-1:0];
   endfunction

   logic                   last_level_ff, last_level_in;
   logic                   edge_seen_ff, edge_seen_in;
   logic                   long_active_ff, long_active_in;
   logic                   deb_pending_ff, deb_pending_in;
   logic [COUNT_WIDTH-1:0] deb_left_ff, deb_left_in;
   logic                   long_armed_ff, long_armed_in;
   logic [COUNT_WIDTH-1:0] long_left_ff, long_left_in;
   press_type              press_ff, press_in;
   logic                   advance;

   always_comb begin
      last_level_in  = last_level_ff;
      edge_seen_in   = edge_seen_ff;
      long_active_in = long_active_ff;
      deb_pending_in = deb_pending_ff;
      deb_left_in    = deb_left_ff;
      long_armed_in  = long_armed_ff;
      long_left_in   = long_left_ff;
      press_in       = press_ff;
      advance        = 1'b0;

      // debounce countdown
      if (deb_pending_ff) begin
         if (deb_left_in != '0) begin
            deb_left_in = deb_left_in - COUNT_WIDTH'(1);
         end
         if (deb_left_in == '0) begin
            press_in       = (!pin && !long_active_ff) ? PRESS_SHORT : PRESS_NONE;
            deb_pending_in = 1'b0;
         end
      end

      // long press countdown
      if (long_armed_ff) begin
         if (long_left_in != '0) begin
            long_left_in = long_left_in - COUNT_WIDTH'(1);
         end
         if (long_left_in == '0) begin
            if (!edge_seen_ff && pin) begin
               if (long_active_ff) begin
                  press_in = PRESS_REPEAT;
                  if (!cfg.suppress_view) begin
                     advance  = 1'b1;
                     press_in = PRESS_NONE;
                  end
               end else begin
                  press_in = PRESS_LONG;
               end
               long_active_in = 1'b1;
               long_left_in   = load_count(cfg.repeat_ticks);
            end else begin
               long_active_in = 1'b0;
               long_armed_in  = 1'b0;
            end
         end
      end

      // rising edge
      if (pin && !last_level_ff) begin
         if (!deb_pending_in && !long_active_in) begin
            deb_pending_in = 1'b1;
            deb_left_in    = load_count(cfg.debounce_ticks);
            long_armed_in  = 1'b1;
            long_left_in   = load_count(cfg.long_press_ticks);
            edge_seen_in   = 1'b0;
         end else begin
            edge_seen_in = 1'b1;
         end
      end
      last_level_in = pin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b0;
         edge_seen_ff   <= 1'b0;
         long_active_ff <= 1'b0;
         deb_pending_ff <= 1'b0;
         deb_left_ff    <= '0;
         long_armed_ff  <= 1'b0;
         long_left_ff   <= '0;
         press_ff       <= PRESS_NONE;
      end else if (step) begin
         last_level_ff  <= last_level_in;
         edge_seen_ff   <= edge_seen_in;
         long_active_ff <= long_active_in;
         deb_pending_ff <= deb_pending_in;
         deb_left_ff    <= deb_left_in;
         long_armed_ff  <= long_armed_in;
         long_left_ff   <= long_left_in;
         press_ff       <= press_in;
      end
   end

   assign result.press_state  = press_in;
   assign result.view_advance = advance;

endmodule

// ----- rtl/core/button_press_classifier.sv -----
// top level: input register, press classification logic and result register
// One pin sample is taken per item and gives exactly one result item. Items
// flow through an input register and a result register, with the press
// state updated as an item moves from one to the other, so a new item is
// accepted every cycle while the output side does not stall, and a stall
// blocks new items once the input register is full. Configuration writes
// take effect on the next cycle and are always accepted; COUNT_WIDTH sets
// the width of the two countdown counters, and delays above its range
// saturate to the largest count.
module button_press_classifier
   import bpc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)(
   input  logic      clock,
   input  logic      reset,
   bpc_req_if.sink   req_chan,
   bpc_rsp_if.source rsp_chan,
   bpc_csr_if.sink   csr_chan
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_pin_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       advance_stage;
   logic       req_take;

   assign csr_chan.ready = 1'b1;

   bpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_idx_type'(csr_chan.index)),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   assign advance_stage    = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance_stage;
   assign req_take         = req_chan.valid && req_chan.ready;

   bpc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance_stage),
      .pin    (in_pin_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance_stage) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance_stage) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pin_ff <= req_chan.pin_level;
      end
      if (advance_stage) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.press_state  = out_data_ff.press_state;
   assign rsp_chan.view_advance = out_data_ff.view_advance;

endmodule

// ----- bench/testbench.sv -----
// testbench: button press classifier checked item by item against a predictor
`timescale 1ns / 1ps

module testbench;
   import bpc_pkg::*;

   localparam int unsigned COUNT_WIDTH    = 16;
   localparam longint unsigned COUNT_MAX  = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_OFF_TICKS = 80;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned SEGMENTS       = 12;
   localparam int unsigned SEGMENT_ITEMS  = 27;

   typedef struct packed {
      logic       is_setting;
      cfg_type    setting;
      logic       pin;
      logic       typed;
      result_type want;
   } step_row_type;

   function automatic step_row_type pin_row(input logic pin);
      step_row_type r;
      r = '0;
      r.pin = pin;
      return r;
   endfunction

   function automatic step_row_type typed_row(input logic pin, input press_type st,
                                              input logic adv);
      step_row_type r;
      r = pin_row(pin);
      r.typed = 1'b1;
      r.want.press_state = st;
      r.want.view_advance = adv;
      return r;
   endfunction

   function automatic step_row_type setting_row(input logic [15:0] deb, input logic [15:0] lng,
                                                input logic [15:0] rpt, input logic sup);
      step_row_type r;
      r = '0;
      r.is_setting = 1'b1;
      r.setting.debounce_ticks = deb;
      r.setting.long_press_ticks = lng;
      r.setting.repeat_ticks = rpt;
      r.setting.suppress_view = sup;
      return r;
   endfunction

   localparam step_row_type DIRECTED_STEPS [0:25] = '{
      typed_row(1'b0, PRESS_NONE, 1'b0),
      typed_row(1'b0, PRESS_NONE, 1'b0),
      // zero debounce acts as one tick
      setting_row(16'd0, 16'd3, 16'd2, 1'b0),
      pin_row(1'b1), pin_row(1'b0), pin_row(1'b0), pin_row(1'b0), pin_row(1'b0),
      pin_row(1'b1), pin_row(1'b1), pin_row(1'b1), pin_row(1'b1),
      pin_row(1'b1), pin_row(1'b1), pin_row(1'b1), pin_row(1'b1),
      pin_row(1'b0), pin_row(1'b1), pin_row(1'b0),
      // repeat with the view pulse suppressed, re-arming a running long countdown
      setting_row(16'd1, 16'd2, 16'd1, 1'b1),
      pin_row(1'b1), pin_row(1'b1), pin_row(1'b1), pin_row(1'b1), pin_row(1'b1),
      pin_row(1'b0)
   };

   logic clock;
   logic reset;

   bpc_req_if req_bus ();
   bpc_rsp_if rsp_bus ();
   bpc_csr_if csr_bus ();

   button_press_classifier #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor state
   cfg_type                shadow_cfg   = '{DEBOUNCE_RESET, LONG_RESET, REPEAT_RESET, 1'b0};
   logic                   last_level   = 1'b0;
   logic                   edge_seen    = 1'b0;
   logic                   long_active  = 1'b0;
   logic                   db_pending   = 1'b0;
   logic                   long_armed   = 1'b0;
   logic [COUNT_WIDTH-1:0] db_left      = '0;
   logic [COUNT_WIDTH-1:0] long_left    = '0;
   press_type              press_code   = PRESS_NONE;

   result_type  expected_presses [$];
   int unsigned error_count    = 0;
   int unsigned items_sent     = 0;
   int unsigned writes_done    = 0;
   int unsigned state_tally [4] = '{0, 0, 0, 0};
   int unsigned advance_tally  = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   bit          hold_off_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [COUNT_WIDTH-1:0] count_load(input logic [15:0] ticks);
      longint unsigned wide;
      wide = (ticks == 16'd0) ? 64'd1 : 64'(ticks);
      if (wide > COUNT_MAX) wide = COUNT_MAX;
      return wide[COUNT_WIDTH-1:0];
   endfunction

   function automatic result_type classify_tick(input logic pin);
      result_type r;
      logic       advance;
      advance = 1'b0;
      if (db_pending) begin
         if (db_left != 0) db_left = db_left - 1'b1;
         if (db_left == 0) begin
            press_code = (!pin && !long_active) ? PRESS_SHORT : PRESS_NONE;
            db_pending = 1'b0;
         end
      end
      if (long_armed) begin
         if (long_left != 0) long_left = long_left - 1'b1;
         if (long_left == 0) begin
            if (!edge_seen && pin) begin
               if (long_active) begin
                  press_code = PRESS_REPEAT;
                  if (!shadow_cfg.suppress_view) begin
                     advance = 1'b1;
                     press_code = PRESS_NONE;
                  end
               end else begin
                  press_code = PRESS_LONG;
               end
               long_active = 1'b1;
               long_left = count_load(shadow_cfg.repeat_ticks);
            end else begin
               long_active = 1'b0;
               long_armed = 1'b0;
            end
         end
      end
      if (pin && !last_level) begin
         if (!db_pending && !long_active) begin
            db_pending = 1'b1;
            db_left = count_load(shadow_cfg.debounce_ticks);
            long_armed = 1'b1;
            long_left = count_load(shadow_cfg.long_press_ticks);
            edge_seen = 1'b0;
         end else begin
            edge_seen = 1'b1;
         end
      end
      last_level = pin;
      r.press_state = press_code;
      r.view_advance = advance;
      return r;
   endfunction

   task automatic send_pin(input logic pin, input logic typed, input result_type want);
      result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pin_level <= pin;
      do @(posedge clock); while (!req_bus.ready);
      predicted = classify_tick(pin);
      expected_presses.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic load_setting(input cfg_type setting);
      csr_idx_type idx;
      logic [15:0] value;
      req_bus.valid <= 1'b0;
      while (expected_presses.size() != 0) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         idx = csr_idx_type'(i);
         case (idx)
            CSR_DEBOUNCE: value = setting.debounce_ticks;
            CSR_LONG:     value = setting.long_press_ticks;
            CSR_REPEAT:   value = setting.repeat_ticks;
            default:      value = {15'd0, setting.suppress_view};
         endcase
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data <= value;
         do @(posedge clock); while (!csr_bus.ready);
         case (idx)
            CSR_DEBOUNCE: shadow_cfg.debounce_ticks = value;
            CSR_LONG:     shadow_cfg.long_press_ticks = value;
            CSR_REPEAT:   shadow_cfg.repeat_ticks = value;
            default:      shadow_cfg.suppress_view = value[0];
         endcase
         writes_done++;
      end
      csr_bus.valid <= 1'b0;
   endtask

   // result side: compare against the oldest expectation, then pick next ready
   initial begin
      result_type  oldest;
      int unsigned hold_left;
      bit          hold_off_done;
      hold_left = 0;
      hold_off_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_presses.size() == 0) begin
               $error("unexpected result item: press_state %0d view_advance %0d",
                      rsp_bus.press_state, rsp_bus.view_advance);
               error_count++;
            end else begin
               oldest = expected_presses.pop_front();
               state_tally[oldest.press_state]++;
               if (oldest.view_advance) advance_tally++;
               if (rsp_bus.press_state !== oldest.press_state) begin
                  $error("press_state: expected %0d, actual %0d",
                         oldest.press_state, rsp_bus.press_state);
                  error_count++;
               end
               if (rsp_bus.view_advance !== oldest.view_advance) begin
                  $error("view_advance: expected %0d, actual %0d",
                         oldest.view_advance, rsp_bus.view_advance);
                  error_count++;
               end
            end
         end
         if (hold_off_request && !hold_off_done) begin
            hold_left = HOLD_OFF_TICKS;
            hold_off_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("button_press_classifier regression: fail");
            $finish;
         end
      end
   end

   initial begin
      cfg_type     setting;
      int unsigned seg_items;
      int unsigned hold;
      int unsigned gap;
      int unsigned blip;
      int unsigned noise_len;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pin_level = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_DEBOUNCE;
      csr_bus.data = '0;
      send_idle_pct = 18;
      recv_idle_pct = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_STEPS[i]) begin
         if (DIRECTED_STEPS[i].is_setting) begin
            load_setting(DIRECTED_STEPS[i].setting);
         end else begin
            send_pin(DIRECTED_STEPS[i].pin, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 4)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (seg == 0) begin
            setting = '{16'd1, 16'd1, 16'd1, 1'b0};
         end else if (seg == 6) begin
            setting = '{16'd0, 16'd0, 16'd0, 1'b0};
         end else if (seg == SEGMENTS - 1) begin
            // longest delays last: a full-range debounce blocks new presses
            setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
         end else begin
            setting.debounce_ticks = 16'($urandom_range(0, 8));
            setting.long_press_ticks = 16'($urandom_range(1, 24));
            setting.repeat_ticks = 16'($urandom_range(1, 12));
            setting.suppress_view = 1'($urandom_range(0, 1));
         end
         load_setting(setting);
         if (seg == 8) hold_off_request = 1'b1;
         seg_items = 0;
         while (seg_items < SEGMENT_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
               noise_len = $urandom_range(1, 8);
               for (int t = 0; t < noise_len; t++) begin
                  send_pin(1'($urandom_range(0, 1)), 1'b0, '0);
               end
               seg_items += noise_len;
            end else begin
               hold = $urandom_range(1, 40);
               gap = $urandom_range(1, 12);
               blip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, hold - 1) : hold;
               for (int t = 0; t < hold; t++) send_pin(t != blip, 1'b0, '0);
               for (int t = 0; t < gap; t++) send_pin(1'b0, 1'b0, '0);
               seg_items += hold + gap;
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_presses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pin items and %0d register writes over three idle profiles",
               items_sent, writes_done);
      $display("results: %0d none, %0d short, %0d long, %0d repeat, %0d view advances",
               state_tally[0], state_tally[1], state_tally[2], state_tally[3], advance_tally);
      if (error_count == 0) begin
         $display("button_press_classifier regression: pass");
      end else begin
         $display("button_press_classifier regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/bpc_pkg.sv
rtl/core/bpc_req_if.sv
rtl/core/bpc_rsp_if.sv
rtl/core/bpc_csr_if.sv
rtl/core/bpc_csr.sv
rtl/core/bpc_core.sv
rtl/core/button_press_classifier.sv
bench/testbench.sv
